/* hw/rtl/lpd_pkg.sv */
package lpd_pkg;

  // field widths
  localparam int unsigned BYTE_W = 8;
  localparam int unsigned LEN_W  = 31;

  // reset value of the frame length limit
  localparam logic [LEN_W-1:0] MAX_FRAME_RST = 31'd16777216;

  // default depth of the result queue
  localparam int unsigned QUEUE_DEPTH_DEF = 4;

  // result event codes
  typedef enum logic [2:0] {
    EV_DATA  = 3'd0,
    EV_EMPTY = 3'd1,
    EV_NEG   = 3'd2,
    EV_OVER  = 3'd3,
    EV_TRUNC = 3'd4,
    EV_CLOSE = 3'd5
  } ev_t;

  // parser phase, one-hot
  typedef enum logic [2:0] {
    PH_PREFIX  = 3'b001,
    PH_PAYLOAD = 3'b010,
    PH_DISCARD = 3'b100
  } phase_t;

  // one result item
  typedef struct packed {
    logic [BYTE_W-1:0] payload_byte;
    logic              last;
    ev_t               event_res;
  } res_t;

  // front to queue
  typedef struct packed {
    logic push;
    res_t res;
  } push_t;

endpackage

/* hw/rtl/length_prefix_deframer.sv */
// channel   direction  handshake              payload
// in_       input      in_valid / in_ready    in_data_byte, in_end_of_stream
// out_      output     out_valid / out_ready  out_payload_byte, out_last, out_event_res
// cfg_      input      cfg_wr_en only         cfg_wr_data (max_frame_bytes)
//
// one item per cycle while the queue is not full: the parser decides each item in the cycle it is accepted
// results sit in a queue of QUEUE_DEPTH entries that drives the out_ ports
// in_ready drops only while the queue is full; the first result shows in the cycle after its item
// synchronous active-low reset empties the queue and rearms the parser in the prefix phase
// reset sets the length limit to 16777216
module length_prefix_deframer #(
  parameter int unsigned QUEUE_DEPTH = lpd_pkg::QUEUE_DEPTH_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        cfg_wr_en,
  input  logic [lpd_pkg::LEN_W-1:0]   cfg_wr_data,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic [lpd_pkg::BYTE_W-1:0]  in_data_byte,
  input  logic                        in_end_of_stream,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic [lpd_pkg::BYTE_W-1:0]  out_payload_byte,
  output logic                        out_last,
  output logic [2:0]                  out_event_res
);

  lpd_pkg::push_t q_push;
  lpd_pkg::res_t  out_res;
  logic           q_full;

  // parser
  lpd_front u_front (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_wr_en        (cfg_wr_en),
    .cfg_wr_data      (cfg_wr_data),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_data_byte     (in_data_byte),
    .in_end_of_stream (in_end_of_stream),
    .q_full           (q_full),
    .q_push           (q_push)
  );

  // result queue
  lpd_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_push    (q_push),
    .q_full    (q_full),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_res   (out_res)
  );

  // unpack result fields
  assign out_payload_byte = out_res.payload_byte;
  assign out_last         = out_res.last;
  assign out_event_res    = out_res.event_res;

endmodule

/* hw/rtl/lpd_front.sv */
module lpd_front (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        cfg_wr_en,
  input  logic [lpd_pkg::LEN_W-1:0]   cfg_wr_data,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic [lpd_pkg::BYTE_W-1:0]  in_data_byte,
  input  logic                        in_end_of_stream,
  input  logic                        q_full,
  output lpd_pkg::push_t              q_push
);

  lpd_pkg::phase_t             phase_r, phase_nxt;
  logic [1:0]                  cnt_r, cnt_nxt;
  logic [23:0]                 shift_r, shift_nxt;
  logic [lpd_pkg::LEN_W-1:0]   left_r, left_nxt;
  logic [lpd_pkg::LEN_W-1:0]   max_r;
  logic [31:0]                 full_len;
  logic                        acc;

  assign in_ready = !q_full;
  assign acc      = in_valid && in_ready;
  assign full_len = {shift_r, in_data_byte};

  // length limit register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_r <= lpd_pkg::MAX_FRAME_RST;
    end else if (cfg_wr_en) begin
      max_r <= cfg_wr_data;
    end
  end

  // prefix gathering, length checks and payload counting
  always_comb begin
    phase_nxt  = phase_r;
    cnt_nxt    = cnt_r;
    shift_nxt  = shift_r;
    left_nxt   = left_r;
    q_push     = '0;
    q_push.res.event_res = lpd_pkg::EV_DATA;
    if (acc) begin
      unique case (phase_r)
        lpd_pkg::PH_PREFIX: begin
          if (in_end_of_stream) begin
            q_push.push          = 1'b1;
            q_push.res.event_res = (cnt_r == 2'd0) ? lpd_pkg::EV_CLOSE : lpd_pkg::EV_TRUNC;
            cnt_nxt              = 2'd0;
            shift_nxt            = '0;
          end else if (cnt_r != 2'd3) begin
            shift_nxt = {shift_r[15:0], in_data_byte};
            cnt_nxt   = cnt_r + 2'd1;
          end else begin
            cnt_nxt   = 2'd0;
            shift_nxt = '0;
            priority if (full_len[31]) begin
              q_push.push          = 1'b1;
              q_push.res.event_res = lpd_pkg::EV_NEG;
              phase_nxt            = lpd_pkg::PH_DISCARD;
            end else if (full_len[30:0] > max_r) begin
              q_push.push          = 1'b1;
              q_push.res.event_res = lpd_pkg::EV_OVER;
              phase_nxt            = lpd_pkg::PH_DISCARD;
            end else if (full_len[30:0] == '0) begin
              q_push.push          = 1'b1;
              q_push.res.last      = 1'b1;
              q_push.res.event_res = lpd_pkg::EV_EMPTY;
            end else begin
              left_nxt  = full_len[30:0];
              phase_nxt = lpd_pkg::PH_PAYLOAD;
            end
          end
        end
        lpd_pkg::PH_PAYLOAD: begin
          q_push.push = 1'b1;
          if (in_end_of_stream) begin
            q_push.res.event_res = lpd_pkg::EV_TRUNC;
            phase_nxt            = lpd_pkg::PH_PREFIX;
            left_nxt             = '0;
          end else begin
            q_push.res.payload_byte = in_data_byte;
            left_nxt                = left_r - 31'd1;
            if (left_r == 31'd1) begin
              q_push.res.last = 1'b1;
              phase_nxt       = lpd_pkg::PH_PREFIX;
            end
          end
        end
        lpd_pkg::PH_DISCARD: begin
          // drop bytes until the stream ends
          if (in_end_of_stream) begin
            phase_nxt = lpd_pkg::PH_PREFIX;
            cnt_nxt   = 2'd0;
            shift_nxt = '0;
            left_nxt  = '0;
          end
        end
        default: begin
          // unused codes drop bytes like the discard phase
          if (in_end_of_stream) begin
            phase_nxt = lpd_pkg::PH_PREFIX;
            cnt_nxt   = 2'd0;
            shift_nxt = '0;
            left_nxt  = '0;
          end
        end
      endcase
    end
  end

  // parser state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= lpd_pkg::PH_PREFIX;
      cnt_r   <= 2'd0;
      shift_r <= '0;
      left_r  <= '0;
    end else begin
      phase_r <= phase_nxt;
      cnt_r   <= cnt_nxt;
      shift_r <= shift_nxt;
      left_r  <= left_nxt;
    end
  end

`ifndef SYNTH
  // a result is only produced for an accepted item
  a_push_needs_accept: assert property (@(posedge clk) disable iff (!rst_n)
    q_push.push |-> acc)
    else $error("result pushed without an accepted item");

  // the final payload byte returns the parser to the prefix phase
  a_last_rearms: assert property (@(posedge clk) disable iff (!rst_n)
    (acc && phase_r == lpd_pkg::PH_PAYLOAD && !in_end_of_stream && left_r == 31'd1)
    |=> (phase_r == lpd_pkg::PH_PREFIX && cnt_r == 2'd0))
    else $error("parser did not rearm after last payload byte");

  // while passing payload there is always at least one byte left
  a_payload_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    (phase_r == lpd_pkg::PH_PAYLOAD) |-> (left_r != '0))
    else $error("payload phase with zero bytes left");
`endif

endmodule

/* hw/rtl/lpd_queue.sv */
module lpd_queue #(
  parameter int unsigned DEPTH = lpd_pkg::QUEUE_DEPTH_DEF
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  lpd_pkg::push_t             q_push,
  output logic                       q_full,
  output logic                       out_valid,
  input  logic                       out_ready,
  output lpd_pkg::res_t              out_res
);

  localparam int unsigned PTR_W = $clog2(DEPTH);
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

  lpd_pkg::res_t     mem_r [DEPTH];
  logic [PTR_W-1:0]  wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0]  rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0]  cnt_r, cnt_nxt;
  logic              pop;

  assign q_full    = (cnt_r == CNT_FULL);
  assign out_valid = (cnt_r != '0);
  assign out_res   = mem_r[rd_ptr_r];
  assign pop       = out_valid && out_ready;

  // pointer and fill count update
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (q_push.push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_LAST) ? '0 : wr_ptr_r + PTR_W'(1);
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_LAST) ? '0 : rd_ptr_r + PTR_W'(1);
    end
    if (q_push.push && !pop) begin
      cnt_nxt = cnt_r + CNT_W'(1);
    end else if (pop && !q_push.push) begin
      cnt_nxt = cnt_r - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  // item storage
  always_ff @(posedge clk) begin
    if (q_push.push) begin
      mem_r[wr_ptr_r] <= q_push.res;
    end
  end

`ifndef SYNTH
  // never written while full
  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    !(q_push.push && q_full))
    else $error("queue written while full");

  // fill count advances on a push without a pop
  a_count_track: assert property (@(posedge clk) disable iff (!rst_n)
    (q_push.push && !pop) |=> (cnt_r == $past(cnt_r) + CNT_W'(1)))
    else $error("queue count did not advance on push");

  // a waiting result stays offered until taken
  a_valid_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ready) |=> out_valid)
    else $error("result withdrawn before it was taken");
`endif

endmodule
